>>> hw/rtl/ssiq_pkg.sv
// Shared types and status codes for the stable sorted insert queue.
package ssiq_pkg;

    localparam logic       MODE_INSERT = 1'b0;
    localparam logic       MODE_DUMP   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DUMPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] arrival_number;
        logic [3:0]  priority_req;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] arrival_out;
        logic [3:0]  priority_out;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] arrival;
        logic [3:0]  prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rot;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

>>> hw/rtl/ssiq_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts or rotates with its neighbors.
module ssiq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssiq_pkg::t_cell_ctl i_ctl,
    input  ssiq_pkg::t_entry   i_left,
    input  logic               i_left_valid,
    input  logic               i_left_go,
    input  ssiq_pkg::t_entry   i_right,
    input  logic               i_right_valid,
    input  ssiq_pkg::t_entry   i_head,
    output ssiq_pkg::t_entry   o_entry,
    output logic               o_valid,
    output logic               o_go
);

    ssiq_pkg::t_entry r_entry;
    ssiq_pkg::t_entry n_entry;
    logic             r_valid;
    logic             n_valid;

    assign o_go    = !r_valid || (r_entry.prio > i_ctl.new_entry.prio);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            n_valid = r_valid | i_left_valid;
            if (i_left_go) begin
                n_entry = i_left;
            end else if (o_go) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.rot) begin
            n_entry = (r_valid && !i_right_valid) ? i_head : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

>>> hw/rtl/stable_sorted_insert_queue.sv
// Top level of the stable sorted insert queue: a chain of cells plus the dump sequencer.
// An insert updates the cell chain at its accepting edge; its result is valid the next cycle.
// A dump of n entries is accepted, then the chain rotates n times, one entry out each;
// a rotation waits while the output register is stalled, and each entry is taken from cell 0.
// An insert is accepted every cycle the output register is free; a dump blocks input.
// Synchronous active-low reset empties the chain; entry contents are not cleared.
module stable_sorted_insert_queue #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ssiq_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output ssiq_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    localparam int CW = $clog2(DEPTH + 1);

    ssiq_pkg::t_entry    w_entry [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_go;
    ssiq_pkg::t_cell_ctl w_ctl;

    logic           r_dumping;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_left;
    logic           r_out_valid;
    ssiq_pkg::t_out r_out_data;

    logic w_can_load;
    logic w_accept;
    logic w_full;

    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_dumping || !w_can_load;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = w_valid[DEPTH-1];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_ctl.ins = w_accept && (i_in_data.mode == ssiq_pkg::MODE_INSERT) && !w_full;
    assign w_ctl.rot = r_dumping && w_can_load;
    assign w_ctl.new_entry.arrival = i_in_data.arrival_number;
    assign w_ctl.new_entry.prio    = i_in_data.priority_req;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ssiq_pkg::t_entry w_left;
        ssiq_pkg::t_entry w_right;
        logic             w_left_valid;
        logic             w_left_go;
        logic             w_right_valid;

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_valid = 1'b1;
            assign w_left_go    = 1'b0;
        end else begin : g_mid
            assign w_left       = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_go    = w_go[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        ssiq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_left_go     (w_left_go),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .i_head        (w_entry[0]),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_go          (w_go[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dumping   <= 1'b0;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.ins) begin
                r_count <= r_count + CW'(1);
            end
            if (w_accept) begin
                if (i_in_data.mode == ssiq_pkg::MODE_INSERT) begin
                    r_out_valid             <= 1'b1;
                    r_out_data.status       <= w_full ? ssiq_pkg::ST_FULL : ssiq_pkg::ST_INSERTED;
                    r_out_data.arrival_out  <= '0;
                    r_out_data.priority_out <= '0;
                    r_out_data.last         <= 1'b1;
                end else if (r_count == '0) begin
                    r_out_valid             <= 1'b1;
                    r_out_data.status       <= ssiq_pkg::ST_EMPTY;
                    r_out_data.arrival_out  <= '0;
                    r_out_data.priority_out <= '0;
                    r_out_data.last         <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                    r_dumping   <= 1'b1;
                    r_left      <= r_count;
                end
            end else if (w_ctl.rot) begin
                r_out_valid             <= 1'b1;
                r_out_data.status       <= ssiq_pkg::ST_DUMPED;
                r_out_data.arrival_out  <= w_entry[0].arrival;
                r_out_data.priority_out <= w_entry[0].prio;
                r_out_data.last         <= (r_left == CW'(1));
                r_left                  <= r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    r_dumping <= 1'b0;
                end
            end else if (w_can_load) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_matches_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(DEPTH)) == w_valid[DEPTH-1])
        else $error("entry count disagrees with the chain fill");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[DEPTH-1] |-> w_valid[0])
        else $error("chain valid bits are not packed toward the front");

    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dumping |-> !w_accept)
        else $error("transaction accepted during a dump");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.mode == ssiq_pkg::MODE_INSERT) && w_full)
        |=> (r_out_valid && (r_out_data.status == ssiq_pkg::ST_FULL) && $stable(r_count)))
        else $error("insert into a full queue was not dropped");

endmodule
